// ===== rtl/core/gfe_pkg.sv =====
// gfe_pkg: shared types, widths and helper functions for the gf(2) polynomial
// extended euclid block. No dependencies.
`default_nettype none

package gfe_pkg;

  // polynomial and field widths
  localparam int POLY_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int DEG_W     = (POLY_BITS > 1) ? $clog2(POLY_BITS) : 1;

  typedef logic [POLY_BITS-1:0] poly_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [DEG_W-1:0]     deg_t;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DEG_ERR = 1'b1;

  // remainder pair with bezout coefficients and cached degrees
  typedef struct packed {
    poly_t v;
    poly_t u;
    poly_t xv;
    poly_t xu;
    poly_t yv;
    poly_t yu;
    deg_t  dv;
    deg_t  du;
  } gfe_regs_t;

  // output of one shift-xor reduction
  typedef struct packed {
    poly_t v;
    poly_t xv;
    poly_t yv;
    deg_t  dv;
  } gfe_red_t;

  // one result item
  typedef struct packed {
    field_t coeff_operand;
    field_t coeff_modulus;
    logic   status;
  } gfe_res_t;

  // degree of a polynomial, zero counts as degree 0
  function automatic deg_t poly_degree(poly_t p);
    deg_t d;
    d = '0;
    for (int i = 1; i < POLY_BITS; i++) begin
      if (p[i]) begin
        d = DEG_W'(i);
      end
    end
    return d;
  endfunction

  // field word to polynomial, keeping the low POLY_BITS bits
  function automatic poly_t to_poly(field_t f);
    poly_t p;
    p = '0;
    for (int i = 0; i < POLY_BITS; i++) begin
      if (i < FIELD_W) begin
        p[i] = f[i];
      end
    end
    return p;
  endfunction

  // polynomial to field word, zero extended or truncated
  function automatic field_t to_field(poly_t p);
    field_t f;
    f = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < POLY_BITS) begin
        f[i] = p[i];
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gfe_in_if.sv =====
// gfe_in_if: valid/ready channel carrying one operand polynomial per item.
// Depends on gfe_pkg for the field type.
`default_nettype none

interface gfe_in_if;
  import gfe_pkg::*;

  logic   valid;
  logic   ready;
  field_t operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gfe_out_if.sv =====
// gfe_out_if: valid/ready channel carrying bezout coefficients and status.
// Depends on gfe_pkg for the field type.
`default_nettype none

interface gfe_out_if;
  import gfe_pkg::*;

  logic   valid;
  logic   ready;
  field_t coeff_operand;
  field_t coeff_modulus;
  logic   status;

  modport source (output valid, output coeff_operand, output coeff_modulus,
                  output status, input ready);
  modport sink   (input valid, input coeff_operand, input coeff_modulus,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gfe_reduce.sv =====
// gfe_reduce: shared shift-xor unit, one reduction step of polynomial division
// with matching updates of both bezout coefficients. Depends on gfe_pkg.
`default_nettype none

module gfe_reduce
  import gfe_pkg::*;
(
  input  gfe_regs_t cur,
  output gfe_red_t  red
);

  deg_t  sh;
  poly_t v_new;

  // align divisor top bit with remainder top bit
  assign sh    = cur.dv - cur.du;
  assign v_new = cur.v ^ (cur.u << sh);

  // same shifted quotient term applied to the coefficients
  always_comb begin
    red.v  = v_new;
    red.xv = cur.xv ^ (cur.xu << sh);
    red.yv = cur.yv ^ (cur.yu << sh);
    red.dv = poly_degree(v_new);
  end

endmodule

`default_nettype wire

// ===== rtl/core/gfe_core.sv =====
// gfe_core: sequencer and working registers of the extended euclid loop,
// plus the result register. Depends on gfe_pkg and gfe_reduce.
`default_nettype none

module gfe_core
  import gfe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire poly_t    modulus,
  input  wire logic     start_valid,
  input  wire poly_t    start_operand,
  output logic          start_ready,
  output logic          res_valid,
  output gfe_res_t      res,
  input  wire logic     res_ready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic      state_r, state_nxt;
  logic      err_r, err_nxt;
  gfe_regs_t regs_r, regs_nxt;
  logic      res_valid_r, res_valid_nxt;
  gfe_res_t  res_r, res_nxt;
  gfe_red_t  red;

  logic start;
  logic finish;
  logic slot_free;
  logic do_reduce;
  deg_t deg_g;
  deg_t deg_f;

  gfe_reduce u_reduce (
    .cur (regs_r),
    .red (red)
  );

  assign start_ready = (state_r == ST_IDLE);
  assign start       = start_valid && start_ready;
  assign deg_g       = poly_degree(start_operand);
  assign deg_f       = poly_degree(modulus);

  // loop ends on a degree error or when the divisor has gone to zero
  assign finish    = err_r || (regs_r.u == '0);
  assign slot_free = !res_valid_r || res_ready;
  assign do_reduce = (regs_r.v != '0) && (regs_r.dv >= regs_r.du);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    regs_nxt      = regs_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          err_nxt     = deg_g > deg_f;
          regs_nxt.v  = modulus;
          regs_nxt.u  = start_operand;
          regs_nxt.xv = '0;
          regs_nxt.xu = poly_t'(1);
          regs_nxt.yv = poly_t'(1);
          regs_nxt.yu = '0;
          regs_nxt.dv = deg_f;
          regs_nxt.du = deg_g;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          // wait for the result register to drain
          if (slot_free) begin
            if (err_r) begin
              res_nxt.coeff_operand = '0;
              res_nxt.coeff_modulus = '0;
              res_nxt.status        = STATUS_DEG_ERR;
            end else begin
              res_nxt.coeff_operand = to_field(regs_r.xv);
              res_nxt.coeff_modulus = to_field(regs_r.yv);
              res_nxt.status        = STATUS_OK;
            end
            res_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (do_reduce) begin
          // one quotient bit: cancel the top bit of the remainder
          regs_nxt.v  = red.v;
          regs_nxt.xv = red.xv;
          regs_nxt.yv = red.yv;
          regs_nxt.dv = red.dv;
        end else begin
          // division done: remainder becomes the next divisor
          regs_nxt.v  = regs_r.u;
          regs_nxt.u  = regs_r.v;
          regs_nxt.xv = regs_r.xu;
          regs_nxt.xu = regs_r.xv;
          regs_nxt.yv = regs_r.yu;
          regs_nxt.yu = regs_r.yv;
          regs_nxt.dv = regs_r.du;
          regs_nxt.du = regs_r.dv;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    regs_r <= regs_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/gf2_poly_extended_euclid_top.sv =====
// Extended euclid over gf(2)[x]: one item in, bezout coefficients out.
// Remainder reductions run one at a time on the single shared shift-xor unit,
// each division ending in a swap of remainder and divisor; a degree error or
// zero operand skips the loop and goes straight to the result.
// One item at a time: in ready stays low from accept until the result is loaded.
// Reset (synchronous, active low) clears the sequencer, output valid and modulus.
`default_nettype none

module gf2_poly_extended_euclid_top
  import gfe_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_we,
  input  wire field_t  cfg_wdata,
  gfe_in_if.sink       in_ch,
  gfe_out_if.source    out_ch
);

  field_t   modulus_r;
  gfe_res_t res;
  logic     res_valid;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  gfe_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .modulus       (to_poly(modulus_r)),
    .start_valid   (in_ch.valid),
    .start_operand (to_poly(in_ch.operand)),
    .start_ready   (in_ch.ready),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (out_ch.ready)
  );

  // result channel
  assign out_ch.valid         = res_valid;
  assign out_ch.coeff_operand = res.coeff_operand;
  assign out_ch.coeff_modulus = res.coeff_modulus;
  assign out_ch.status        = res.status;

endmodule

`default_nettype wire

// ===== rtl/core/gfe_chk.sv =====
// gfe_chk: port-level checks for the extended euclid top level, bound to it.
// Depends on gfe_pkg and gf2_poly_extended_euclid_top.
`default_nettype none

module gfe_chk
  import gfe_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire field_t out_coeff_operand,
  input wire logic   out_status
);

  // one item at a time: no new item right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item still running");

  // a degree error gives a zero operand coefficient
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_DEG_ERR)) |-> (out_coeff_operand == '0))
    else $error("degree error with nonzero coefficient");

  // a result appears only after some item was taken
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a running item");

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_coeff_operand)))
    else $error("stalled result dropped or changed");

endmodule

bind gf2_poly_extended_euclid_top gfe_chk u_gfe_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_coeff_operand (out_ch.coeff_operand),
  .out_status        (out_ch.status)
);

`default_nettype wire
